// ----- rtl/tccb_pkg.sv -----
// Shared constants and helpers for the tilt compensated compass bearing block.
// Holds the fixed-point angle constants and the CORDIC arctangent table.
// Used by every module of the block but tccb_fifo; depends on nothing.
package tccb_pkg;

  // Default widths and iteration counts.
  localparam int unsigned SensorBitsDef  = 16;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanTableLen   = 24;

  // Fixed widths of the angle and result fields.
  localparam int unsigned AngW     = 16;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned BearingW = 9;
  localparam logic [BearingW-1:0] MaxBearing = 9'd359;

  // Q30 radian constants and the Q30 CORDIC gain correction.
  localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [32:0] GainQ30   = 33'sd652032874;

  // 180/pi in Q24; scales Q30 radians to Q54 degrees.
  localparam logic [29:0] DegPerRadQ24 = 30'd961263669;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic signed [32:0] atan_q30(input int unsigned idx);
    logic signed [32:0] v;
    case (idx)
      0:  v = 33'sd843314857;
      1:  v = 33'sd497837829;
      2:  v = 33'sd263043837;
      3:  v = 33'sd133525159;
      4:  v = 33'sd67021687;
      5:  v = 33'sd33543516;
      6:  v = 33'sd16775851;
      7:  v = 33'sd8388437;
      8:  v = 33'sd4194283;
      9:  v = 33'sd2097149;
      10: v = 33'sd1048576;
      11: v = 33'sd524288;
      12: v = 33'sd262144;
      13: v = 33'sd131072;
      14: v = 33'sd65536;
      15: v = 33'sd32768;
      16: v = 33'sd16384;
      17: v = 33'sd8192;
      18: v = 33'sd4096;
      19: v = 33'sd2048;
      20: v = 33'sd1024;
      21: v = 33'sd512;
      22: v = 33'sd256;
      23: v = 33'sd128;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/tccb_fifo.sv -----
// Small first-in first-out queue built from flip-flops.
// Used between the front and back pipelines and on the result side.
// Depends on nothing.
module tccb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW:0]   wr_ptr_q, wr_ptr_d;
  logic [AddrW:0]   rd_ptr_q, rd_ptr_d;

  // Pointer update; the extra bit separates full from empty.
  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = (pop_i && !empty_o) ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign empty_o  = (wr_ptr_q == rd_ptr_q);
  assign rdata_o  = mem_q[rd_ptr_q[AddrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[AddrW-1:0]] <= wdata_i;
    end
  end

endmodule

// ----- rtl/tccb_front.sv -----
// Front pipeline: range reduction and rotation CORDIC for sine and cosine
// of roll and pitch, rounded to Q1.14. Depends on tccb_pkg.
module tccb_front #(
  parameter int unsigned SensorBits  = tccb_pkg::SensorBitsDef,
  parameter int unsigned CordicSteps = tccb_pkg::CordicStepsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [SensorBits-1:0]       mag_x_i,
  input  logic signed [SensorBits-1:0]       mag_y_i,
  input  logic signed [SensorBits-1:0]       mag_z_i,
  input  logic signed [tccb_pkg::AngW-1:0]   roll_i,
  input  logic signed [tccb_pkg::AngW-1:0]   pitch_i,
  output logic                               valid_o,
  output logic signed [SensorBits-1:0]       mag_x_o,
  output logic signed [SensorBits-1:0]       mag_y_o,
  output logic signed [SensorBits-1:0]       mag_z_o,
  output logic signed [tccb_pkg::TrigW-1:0]  sin_roll_o,
  output logic signed [tccb_pkg::TrigW-1:0]  cos_roll_o,
  output logic signed [tccb_pkg::TrigW-1:0]  sin_pitch_o,
  output logic signed [tccb_pkg::TrigW-1:0]  cos_pitch_o
);

  // The arctangent table bounds the number of useful steps.
  localparam int unsigned Steps = (CordicSteps > tccb_pkg::AtanTableLen) ?
                                  tccb_pkg::AtanTableLen : CordicSteps;
  localparam int unsigned MagW  = 3 * SensorBits;

  // Per-stage state; index 0 is roll, index 1 is pitch.
  logic signed [32:0]   cx_q  [Steps+1][2];
  logic signed [32:0]   cy_q  [Steps+1][2];
  logic signed [32:0]   cz_q  [Steps+1][2];
  logic                 neg_q [Steps+1][2];
  logic [MagW-1:0]      mag_q [Steps+2];
  logic [Steps+1:0]     vld_q;

  logic signed [33:0]   zf    [2];
  logic signed [33:0]   zr    [2];
  logic                 nr    [2];

  logic signed [32:0]   xn    [2];
  logic signed [32:0]   yn    [2];
  logic signed [32:0]   xr    [2];
  logic signed [32:0]   yr    [2];
  logic signed [tccb_pkg::TrigW-1:0] sin_q [2];
  logic signed [tccb_pkg::TrigW-1:0] cos_q [2];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps:0], valid_i};
    end
  end

  // Fold angles beyond a quarter turn back by a half turn.
  always_comb begin
    zf[0] = {{2{roll_i[15]}}, roll_i, 16'b0} <<< 1;
    zf[1] = {{2{pitch_i[15]}}, pitch_i, 16'b0} <<< 1;
    for (int k = 0; k < 2; k++) begin
      if (zf[k] > tccb_pkg::Q30HalfPi) begin
        zr[k] = zf[k] - tccb_pkg::Q30Pi;
        nr[k] = 1'b1;
      end else if (zf[k] < -tccb_pkg::Q30HalfPi) begin
        zr[k] = zf[k] + tccb_pkg::Q30Pi;
        nr[k] = 1'b1;
      end else begin
        zr[k] = zf[k];
        nr[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      cx_q[0][k]  <= tccb_pkg::GainQ30;
      cy_q[0][k]  <= '0;
      cz_q[0][k]  <= zr[k][32:0];
      neg_q[0][k] <= nr[k];
    end
    mag_q[0] <= {mag_x_i, mag_y_i, mag_z_i};
  end

  // One rotation step per stage.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 2; k++) begin
        if (cz_q[i][k] >= 0) begin
          cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] - tccb_pkg::atan_q30(i);
        end else begin
          cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] + tccb_pkg::atan_q30(i);
        end
        neg_q[i+1][k] <= neg_q[i][k];
      end
      mag_q[i+1] <= mag_q[i];
    end
  end

  // Undo the fold and round Q30 to Q1.14.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      xn[k] = neg_q[Steps][k] ? -cx_q[Steps][k] : cx_q[Steps][k];
      yn[k] = neg_q[Steps][k] ? -cy_q[Steps][k] : cy_q[Steps][k];
      xr[k] = (xn[k] + 33'sd32768) >>> 16;
      yr[k] = (yn[k] + 33'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      cos_q[k] <= xr[k][tccb_pkg::TrigW-1:0];
      sin_q[k] <= yr[k][tccb_pkg::TrigW-1:0];
    end
    mag_q[Steps+1] <= mag_q[Steps];
  end

  assign valid_o     = vld_q[Steps+1];
  assign mag_x_o     = mag_q[Steps+1][MagW-1 -: SensorBits];
  assign mag_y_o     = mag_q[Steps+1][2*SensorBits-1 -: SensorBits];
  assign mag_z_o     = mag_q[Steps+1][SensorBits-1:0];
  assign sin_roll_o  = sin_q[0];
  assign cos_roll_o  = cos_q[0];
  assign sin_pitch_o = sin_q[1];
  assign cos_pitch_o = cos_q[1];

endmodule

// ----- rtl/tccb_back.sv -----
// Back pipeline: tilt rotation of the field, vectoring CORDIC for atan2,
// and conversion to whole degrees of bearing. Depends on tccb_pkg.
module tccb_back #(
  parameter int unsigned SensorBits  = tccb_pkg::SensorBitsDef,
  parameter int unsigned CordicSteps = tccb_pkg::CordicStepsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [SensorBits-1:0]        mag_x_i,
  input  logic signed [SensorBits-1:0]        mag_y_i,
  input  logic signed [SensorBits-1:0]        mag_z_i,
  input  logic signed [tccb_pkg::TrigW-1:0]   sin_roll_i,
  input  logic signed [tccb_pkg::TrigW-1:0]   cos_roll_i,
  input  logic signed [tccb_pkg::TrigW-1:0]   sin_pitch_i,
  input  logic signed [tccb_pkg::TrigW-1:0]   cos_pitch_i,
  output logic                                valid_o,
  output logic [tccb_pkg::BearingW-1:0]       bearing_o
);

  // The arctangent table bounds the number of useful steps.
  localparam int unsigned Steps = (CordicSteps > tccb_pkg::AtanTableLen) ?
                                  tccb_pkg::AtanTableLen : CordicSteps;
  localparam int unsigned XctW  = SensorBits + 16;
  localparam int unsigned TW    = SensorBits + 32;
  localparam int unsigned HW    = SensorBits + 30;
  localparam int unsigned VW    = SensorBits + 32;
  localparam int unsigned Lat   = Steps + 7;

  localparam logic signed [65:0] Deg90Q54  = 66'sd90 <<< 54;
  localparam logic signed [65:0] Deg450Q54 = 66'sd450 <<< 54;

  logic [Lat-1:0] vld_q;

  // Tilt rotation registers.
  logic signed [31:0]            pss_q, psc_q;
  logic signed [XctW-1:0]        xct_q, xct2_q;
  logic signed [SensorBits-1:0]  y1_q, z1_q;
  logic signed [tccb_pkg::TrigW-1:0] sr1_q, cr1_q;
  logic signed [TW-1:0]          t1_q, t2_q;
  logic signed [XctW-1:0]        u1_q, u2_q;
  logic signed [HW-1:0]          hx_q, hy_q;

  // Vectoring stages.
  logic signed [VW-1:0]  vx_q [Steps+1];
  logic signed [VW-1:0]  vy_q [Steps+1];
  logic signed [33:0]    vz_q [Steps+1];
  logic                  vzr_q [Steps+1];

  // Degree conversion.
  logic signed [33:0]    ang;
  logic [46:0]           plo_q;
  logic signed [47:0]    phi_q;
  logic signed [65:0]    prod_q;
  logic signed [65:0]    b90, b450, bsel;
  logic [11:0]           deg;
  logic [tccb_pkg::BearingW-1:0] bearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // First products of the sines and cosines.
  always_ff @(posedge clk_i) begin
    pss_q <= 32'(sin_pitch_i) * 32'(sin_roll_i);
    psc_q <= 32'(sin_pitch_i) * 32'(cos_roll_i);
    xct_q <= XctW'(mag_x_i) * XctW'(cos_pitch_i);
    y1_q  <= mag_y_i;
    z1_q  <= mag_z_i;
    sr1_q <= sin_roll_i;
    cr1_q <= cos_roll_i;
  end

  // Products with the field components.
  always_ff @(posedge clk_i) begin
    t1_q   <= TW'(y1_q) * TW'(pss_q);
    t2_q   <= TW'(z1_q) * TW'(psc_q);
    u1_q   <= XctW'(z1_q) * XctW'(sr1_q);
    u2_q   <= XctW'(y1_q) * XctW'(cr1_q);
    xct2_q <= xct_q;
  end

  // Horizontal components at scale 2^28.
  always_ff @(posedge clk_i) begin
    hx_q <= (HW'(xct2_q) <<< 14) + HW'(t1_q) + HW'(t2_q);
    hy_q <= (HW'(u1_q) - HW'(u2_q)) <<< 14;
  end

  // Start of atan2: move a vector with negative y into the right half plane.
  always_ff @(posedge clk_i) begin
    vzr_q[0] <= (hx_q == '0) && (hy_q == '0);
    if (hy_q < 0) begin
      vx_q[0] <= -VW'(hy_q);
      vy_q[0] <= -VW'(hx_q);
      vz_q[0] <= (hx_q >= 0) ? tccb_pkg::Q30Pi : -tccb_pkg::Q30Pi;
    end else begin
      vx_q[0] <= VW'(hy_q);
      vy_q[0] <= VW'(hx_q);
      vz_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (vy_q[i] >= 0) begin
        vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] + 34'(tccb_pkg::atan_q30(i));
      end else begin
        vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] - 34'(tccb_pkg::atan_q30(i));
      end
      vzr_q[i+1] <= vzr_q[i];
    end
  end

  // Radians to degrees, split in two partial products.
  assign ang = vzr_q[Steps] ? '0 : vz_q[Steps];

  always_ff @(posedge clk_i) begin
    plo_q <= 47'(ang[16:0]) * 47'(tccb_pkg::DegPerRadQ24);
    phi_q <= 48'(signed'(ang[33:17])) * 48'(signed'({1'b0, tccb_pkg::DegPerRadQ24}));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (66'(phi_q) <<< 17) + signed'({19'b0, plo_q});
  end

  // Bearing is 90 minus the angle, wrapped into one turn and truncated.
  always_comb begin
    b90  = Deg90Q54 - prod_q;
    b450 = Deg450Q54 - prod_q;
    bsel = (b90 < 0) ? b450 : b90;
    deg  = bsel[65:54];
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= (deg > 12'(tccb_pkg::MaxBearing)) ? tccb_pkg::MaxBearing
                                                 : deg[tccb_pkg::BearingW-1:0];
  end

  assign valid_o   = vld_q[Lat-1];
  assign bearing_o = bearing_q;

endmodule

// ----- rtl/tilt_compensated_compass_bearing.sv -----
// Top level of the tilt compensated compass bearing block.
// Instantiates tccb_front, tccb_back and two tccb_fifo queues; uses tccb_pkg.
//
//   Channel | Handshake           | Beat
//   --------+---------------------+--------------------------------------------
//   input   | push_i / full_o     | mag_x_i, mag_y_i, mag_z_i, roll_angle_i,
//           |                     | pitch_angle_i
//   result  | empty_o / pop_i     | bearing_deg_o
//
// One beat is accepted per cycle while full_o is low. Each beat passes through
// the front pipeline, the middle queue, the back pipeline and the result queue.
// Credit counters keep each pipeline from issuing more beats than its queue
// can hold, so the front stalls only when the middle queue fills and the back
// only when results are not popped. Reset clears all pointers and counters.
module tilt_compensated_compass_bearing #(
  parameter int unsigned SENSOR_BITS  = tccb_pkg::SensorBitsDef,
  parameter int unsigned CORDIC_STEPS = tccb_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic signed [SENSOR_BITS-1:0]     mag_x_i,
  input  logic signed [SENSOR_BITS-1:0]     mag_y_i,
  input  logic signed [SENSOR_BITS-1:0]     mag_z_i,
  input  logic signed [tccb_pkg::AngW-1:0]  roll_angle_i,
  input  logic signed [tccb_pkg::AngW-1:0]  pitch_angle_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [tccb_pkg::BearingW-1:0]     bearing_deg_o
);

  localparam int unsigned QDepth = 1 << $clog2(CORDIC_STEPS + 8);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned TrigW  = tccb_pkg::TrigW;
  localparam int unsigned MidW   = 3 * SENSOR_BITS + 4 * TrigW;

  logic in_acc, mid_pop, out_pop;
  logic [CntW-1:0] front_cnt_q, front_cnt_d, back_cnt_q, back_cnt_d;

  logic                         f_valid;
  logic signed [SENSOR_BITS-1:0] f_x, f_y, f_z, b_x, b_y, b_z;
  logic signed [TrigW-1:0]      f_sr, f_cr, f_sp, f_cp, b_sr, b_cr, b_sp, b_cp;
  logic [MidW-1:0]              mid_rdata;
  logic                         mid_empty;
  logic                         b_valid;
  logic [tccb_pkg::BearingW-1:0] b_bearing;

  // Handshakes and issue conditions.
  assign in_acc  = push_i && !full_o;
  assign full_o  = (front_cnt_q == CntW'(QDepth));
  assign mid_pop = !mid_empty && (back_cnt_q != CntW'(QDepth));
  assign out_pop = pop_i && !empty_o;

  // Credits: beats in a pipeline plus beats waiting in its queue.
  always_comb begin
    front_cnt_d = front_cnt_q;
    if (in_acc && !mid_pop) begin
      front_cnt_d = front_cnt_q + 1'b1;
    end else if (!in_acc && mid_pop) begin
      front_cnt_d = front_cnt_q - 1'b1;
    end
    back_cnt_d = back_cnt_q;
    if (mid_pop && !out_pop) begin
      back_cnt_d = back_cnt_q + 1'b1;
    end else if (!mid_pop && out_pop) begin
      back_cnt_d = back_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cnt_q <= '0;
      back_cnt_q  <= '0;
    end else begin
      front_cnt_q <= front_cnt_d;
      back_cnt_q  <= back_cnt_d;
    end
  end

  tccb_front #(
    .SensorBits (SENSOR_BITS),
    .CordicSteps(CORDIC_STEPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_acc),
    .mag_x_i    (mag_x_i),
    .mag_y_i    (mag_y_i),
    .mag_z_i    (mag_z_i),
    .roll_i     (roll_angle_i),
    .pitch_i    (pitch_angle_i),
    .valid_o    (f_valid),
    .mag_x_o    (f_x),
    .mag_y_o    (f_y),
    .mag_z_o    (f_z),
    .sin_roll_o (f_sr),
    .cos_roll_o (f_cr),
    .sin_pitch_o(f_sp),
    .cos_pitch_o(f_cp)
  );

  // Queue between the two pipelines.
  tccb_fifo #(
    .Width(MidW),
    .Depth(QDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .wdata_i({f_x, f_y, f_z, f_sr, f_cr, f_sp, f_cp}),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  assign {b_x, b_y, b_z, b_sr, b_cr, b_sp, b_cp} = mid_rdata;

  tccb_back #(
    .SensorBits (SENSOR_BITS),
    .CordicSteps(CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mid_pop),
    .mag_x_i    (b_x),
    .mag_y_i    (b_y),
    .mag_z_i    (b_z),
    .sin_roll_i (b_sr),
    .cos_roll_i (b_cr),
    .sin_pitch_i(b_sp),
    .cos_pitch_i(b_cp),
    .valid_o    (b_valid),
    .bearing_o  (b_bearing)
  );

  // Result queue.
  tccb_fifo #(
    .Width(tccb_pkg::BearingW),
    .Depth(QDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (b_valid),
    .wdata_i(b_bearing),
    .pop_i  (pop_i),
    .rdata_o(bearing_deg_o),
    .empty_o(empty_o)
  );

endmodule

// ----- rtl/tccb_checker.sv -----
// Port-level checks for the tilt compensated compass bearing block,
// bound to the top level. Depends on tccb_pkg.
module tccb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push_i,
  input logic                          full_o,
  input logic                          pop_i,
  input logic                          empty_o,
  input logic [tccb_pkg::BearingW-1:0] bearing_deg_o
);

  // A shown bearing is always within one turn.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> bearing_deg_o <= tccb_pkg::MaxBearing)
    else $error("bearing out of range");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(bearing_deg_o))
    else $error("waiting result changed");

  // The input side fills only after a beat was taken.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("full without a push");

endmodule

bind tilt_compensated_compass_bearing tccb_checker u_tccb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push_i       (push_i),
  .full_o       (full_o),
  .pop_i        (pop_i),
  .empty_o      (empty_o),
  .bearing_deg_o(bearing_deg_o)
);
